// ----- hdl/dqd_pkg.sv -----
// Package for the dual quadrature decoder: command codes, the input item type
// and the x4 quadrature step function.
// No dependencies.
`default_nettype none

package dqd_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_READ_CLEAR = 2'd2;
    localparam logic [1:0] MODE_ADD    = 2'd3;

    // Step codes: two-bit signed values.
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    // Bit places of the pin levels within the four-bit pin group.
    localparam int PIN_LEFT_A  = 0;
    localparam int PIN_LEFT_B  = 1;
    localparam int PIN_RIGHT_A = 2;
    localparam int PIN_RIGHT_B = 3;

    // One input item as the core sees it.
    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         pins;
        logic signed [15:0] offset_left;
        logic signed [15:0] offset_right;
    } dqd_item_t;

    // x4 decode of one wheel. Phase A takes priority when both phases change.
    function automatic logic [1:0] quad_step(input logic a, input logic b,
                                             input logic pa, input logic pb);
        logic [1:0] step;
        step = STEP_NONE;
        if (a != pa) begin
            if (a) begin
                step = b ? STEP_DOWN : STEP_UP;
            end else begin
                step = b ? STEP_UP : STEP_DOWN;
            end
        end else if (b != pb) begin
            if (b) begin
                step = a ? STEP_UP : STEP_DOWN;
            end else begin
                step = a ? STEP_DOWN : STEP_UP;
            end
        end
        return step;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dqd_core.sv -----
// Position state of both wheels and the update for one item.
// Depends on dqd_pkg for the item type, command codes and step function.
`default_nettype none

module dqd_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   accept,
    input  wire dqd_pkg::dqd_item_t     item,
    output logic [COUNT_WIDTH-1:0]      shown_left,
    output logic [COUNT_WIDTH-1:0]      shown_right
);

    logic [COUNT_WIDTH-1:0] left_count_reg, left_count_next;
    logic [COUNT_WIDTH-1:0] right_count_reg, right_count_next;
    logic [3:0]             prior_pins_reg, prior_pins_next;

    logic [1:0]  step_left, step_right;
    logic [63:0] step_left_ext, step_right_ext, off_left_ext, off_right_ext;

    // Decode steps against the pins of the last sample.
    always_comb begin
        step_left  = dqd_pkg::quad_step(item.pins[dqd_pkg::PIN_LEFT_A],
                                        item.pins[dqd_pkg::PIN_LEFT_B],
                                        prior_pins_reg[dqd_pkg::PIN_LEFT_A],
                                        prior_pins_reg[dqd_pkg::PIN_LEFT_B]);
        step_right = dqd_pkg::quad_step(item.pins[dqd_pkg::PIN_RIGHT_A],
                                        item.pins[dqd_pkg::PIN_RIGHT_B],
                                        prior_pins_reg[dqd_pkg::PIN_RIGHT_A],
                                        prior_pins_reg[dqd_pkg::PIN_RIGHT_B]);
        step_left_ext  = {{62{step_left[1]}}, step_left};
        step_right_ext = {{62{step_right[1]}}, step_right};
        off_left_ext   = {{48{item.offset_left[15]}}, item.offset_left};
        off_right_ext  = {{48{item.offset_right[15]}}, item.offset_right};
    end

    // Next state and the positions shown with this item.
    always_comb begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        prior_pins_next  = prior_pins_reg;
        shown_left       = left_count_reg;
        shown_right      = right_count_reg;
        case (item.mode)
            dqd_pkg::MODE_SAMPLE: begin
                left_count_next  = left_count_reg + step_left_ext[COUNT_WIDTH-1:0];
                right_count_next = right_count_reg - step_right_ext[COUNT_WIDTH-1:0];
                prior_pins_next  = item.pins;
                shown_left       = left_count_next;
                shown_right      = right_count_next;
            end
            dqd_pkg::MODE_CLEAR: begin
                left_count_next  = '0;
                right_count_next = '0;
                shown_left       = '0;
                shown_right      = '0;
            end
            dqd_pkg::MODE_READ_CLEAR: begin
                left_count_next  = '0;
                right_count_next = '0;
            end
            dqd_pkg::MODE_ADD: begin
                left_count_next  = left_count_reg + off_left_ext[COUNT_WIDTH-1:0];
                right_count_next = right_count_reg + off_right_ext[COUNT_WIDTH-1:0];
                shown_left       = left_count_next;
                shown_right      = right_count_next;
            end
            default: begin
                left_count_next  = left_count_reg;
                right_count_next = right_count_reg;
            end
        endcase
    end

    // State advances only on an accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            prior_pins_reg  <= '0;
        end else if (accept) begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            prior_pins_reg  <= prior_pins_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dqd_skid.sv -----
// Two-entry output register with skid stage for the result channel.
// No dependencies.
`default_nettype none

module dqd_skid #(
    parameter int WIDTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             main_valid_reg, skid_valid_reg;
    logic [WIDTH-1:0] main_data_reg, skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Control: the main entry refills when it is empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dual_quadrature_decoder_top.sv -----
// Top level of the dual quadrature decoder: unpacks the input stream, runs the
// position core and buffers results. Depends on dqd_pkg, dqd_core, dqd_skid.
//
// Channel   Direction  Ports                              Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  pins, offsets; mode
// m_        out        m_tvalid m_tready m_tdata          counts and their sum
//
// One item per cycle is sustained while m_tready is high. The state update
// is a COUNT_WIDTH-bit add or subtract per wheel in the core, or a clear; the
// result enters the output buffer at the edge that accepts the item and is
// offered from the following cycle if no result waits ahead. Reset clears both
// positions and the prior pins. The two-entry output buffer keeps s_tready high
// while one result waits; s_tready falls only when both entries hold results.
`default_nettype none

module dual_quadrature_decoder_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] left_pin_a, [1] left_pin_b, [2] right_pin_a, [3] right_pin_b,
    // [19:4] offset_left, [35:20] offset_right, [39:36] zero
    input  wire logic [39:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] count_left, [63:32] count_right, [96:64] count_sum, [103:97] zero
    output logic [103:0]      m_tdata
);

    localparam int EXT_WIDTH = (COUNT_WIDTH > 33) ? COUNT_WIDTH : 33;

    dqd_pkg::dqd_item_t     item;
    logic                   accept;
    logic [COUNT_WIDTH-1:0] shown_left, shown_right;
    logic [COUNT_WIDTH-1:0] out_left, out_right;
    logic [EXT_WIDTH-1:0]   ext_left, ext_right, ext_sum;

    // Unpack the input transfer.
    always_comb begin
        item.mode         = s_tuser;
        item.pins         = s_tdata[3:0];
        item.offset_left  = s_tdata[19:4];
        item.offset_right = s_tdata[35:20];
    end

    assign accept = s_tvalid && s_tready;

    dqd_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (item),
        .shown_left  (shown_left),
        .shown_right (shown_right)
    );

    dqd_skid #(
        .WIDTH(2 * COUNT_WIDTH)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_tready),
        .in_data   ({shown_right, shown_left}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  ({out_right, out_left})
    );

    // Sign-extend the buffered positions and form their sum.
    always_comb begin
        ext_left  = EXT_WIDTH'($signed(out_left));
        ext_right = EXT_WIDTH'($signed(out_right));
        ext_sum   = ext_left + ext_right;
        m_tdata   = {7'd0, ext_sum[32:0], ext_right[31:0], ext_left[31:0]};
    end

endmodule

`default_nettype wire
